@@ design/mpbr_pkg.sv @@
// Shared types, constants and helper functions for the mip pyramid box reducer.
// Used by every module of the block except mpbr_ram; no dependencies.
package mpbr_pkg;

    localparam int MAX_WIDTH  = 4096;
    localparam int MAX_LEVELS = 12;

    localparam int DIM_W     = $clog2(MAX_WIDTH) + 1;  // holds MAX_WIDTH itself
    localparam int CNT_W     = $clog2(MAX_WIDTH);      // position within a level
    localparam int COORD_W   = 11;
    localparam int CH_W      = 8;
    localparam int HS_W      = CH_W + 1;               // sum of two channel values
    localparam int SUM_W     = CH_W + 2;               // sum of four channel values
    localparam int LVL_W     = 4;
    localparam int LIDX_W    = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;
    localparam int CFG_W     = 13;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] REG_BASE_WIDTH  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_BASE_HEIGHT = CFG_IDX_W'(1);
    localparam logic [CFG_W-1:0]     BASE_DIM_RESET  = CFG_W'(256);

    // upper-row store depth of level k (1 based): the widest that level can be
    function automatic int ram_depth(input int k);
        int d;
        d = MAX_WIDTH >> k;
        return (d < 1) ? 1 : d;
    endfunction

    function automatic int ram_aw(input int k);
        int d;
        d = ram_depth(k);
        return (d > 1) ? $clog2(d) : 1;
    endfunction

    typedef struct packed {
        logic [CH_W-1:0] alpha;
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
    } pix_t;

    typedef struct packed {
        logic [HS_W-1:0] alpha;
        logic [HS_W-1:0] red;
        logic [HS_W-1:0] green;
        logic [HS_W-1:0] blue;
    } hs_t;

    typedef struct packed {
        logic               valid;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        pix_t               px;
        logic               lop;
    } res_t;

    // one base pixel travelling down the chain, collecting its level results
    typedef struct packed {
        logic                        valid;
        logic                        alive;
        pix_t                        px;
        res_t [MAX_LEVELS-1:0]       res;
    } tok_t;

    typedef struct packed {
        logic             en;
        logic             last;
        logic [DIM_W-1:0] sx;
        logic [DIM_W-1:0] sy;
        logic [DIM_W-1:0] dx;
        logic [DIM_W-1:0] dy;
    } geom_t;

    typedef struct packed {
        logic               we;
        logic               re;
        logic [COORD_W-1:0] addr;
        hs_t                wdata;
    } ram_req_t;

endpackage

@@ design/mip_pyramid_box_reduce.sv @@
// Top level of the streaming mip pyramid builder: config registers, level
// geometry, the chain of level cells with their upper-row stores, output stage.
// Depends on mpbr_pkg, mpbr_cell, mpbr_ram, mpbr_serializer.
//
//   channel  handshake              payload
//   cfg      cfg_we                 cfg_index, cfg_data
//   in       in_valid / in_ready    in_blue, in_green, in_red, in_alpha
//   out      out_valid / out_ready  level, out_x, out_y, out_*, last_of_run,
//                                   last_of_pyramid
//
// One base pixel enters per cycle while the chain advances; each level cell
// registers its token in stage A, then in stage B. Results leave the output
// stage one per cycle while out_ready is high, in level order; a pixel holds
// the chain until its last result is taken: the whole chain stalls together.
// Reset sets 256x256 and clears all counters.
module mip_pyramid_box_reduce (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [mpbr_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [mpbr_pkg::CFG_W-1:0]         cfg_data,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [mpbr_pkg::CH_W-1:0]          in_blue,
    input  logic [mpbr_pkg::CH_W-1:0]          in_green,
    input  logic [mpbr_pkg::CH_W-1:0]          in_red,
    input  logic [mpbr_pkg::CH_W-1:0]          in_alpha,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [mpbr_pkg::LVL_W-1:0]         level,
    output logic [mpbr_pkg::COORD_W-1:0]       out_x,
    output logic [mpbr_pkg::COORD_W-1:0]       out_y,
    output logic [mpbr_pkg::CH_W-1:0]          out_blue,
    output logic [mpbr_pkg::CH_W-1:0]          out_green,
    output logic [mpbr_pkg::CH_W-1:0]          out_red,
    output logic [mpbr_pkg::CH_W-1:0]          out_alpha,
    output logic                               last_of_run,
    output logic                               last_of_pyramid
);

    localparam int L = mpbr_pkg::MAX_LEVELS;

    logic [mpbr_pkg::CFG_W-1:0] base_w_reg, base_h_reg;
    logic                       restart, adv;
    logic [mpbr_pkg::DIM_W-1:0] wc, hc;
    logic [mpbr_pkg::DIM_W-1:0] dim_w [L+1];
    logic [mpbr_pkg::DIM_W-1:0] dim_h [L+1];
    logic [L:0]                 lvl_en;
    mpbr_pkg::geom_t            geom [L];
    mpbr_pkg::tok_t             chain [L+1];
    mpbr_pkg::ram_req_t         req [L];
    mpbr_pkg::hs_t              rdata [L];

    assign restart = cfg_we && (cfg_index == mpbr_pkg::REG_BASE_WIDTH
                             || cfg_index == mpbr_pkg::REG_BASE_HEIGHT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_w_reg <= mpbr_pkg::BASE_DIM_RESET;
            base_h_reg <= mpbr_pkg::BASE_DIM_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                mpbr_pkg::REG_BASE_WIDTH:  base_w_reg <= cfg_data;
                mpbr_pkg::REG_BASE_HEIGHT: base_h_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // level k is max(base >> k, 1); level k exists while level k-1 is not 1x1
    always_comb
    begin
        wc = (base_w_reg == '0) ? mpbr_pkg::DIM_W'(1)
           : (base_w_reg > mpbr_pkg::DIM_W'(mpbr_pkg::MAX_WIDTH))
             ? mpbr_pkg::DIM_W'(mpbr_pkg::MAX_WIDTH) : base_w_reg;
        hc = (base_h_reg == '0) ? mpbr_pkg::DIM_W'(1)
           : (base_h_reg > mpbr_pkg::DIM_W'(mpbr_pkg::MAX_WIDTH))
             ? mpbr_pkg::DIM_W'(mpbr_pkg::MAX_WIDTH) : base_h_reg;
        for (int k = 0; k <= L; k++)
        begin
            dim_w[k] = ((wc >> k) == '0) ? mpbr_pkg::DIM_W'(1) : (wc >> k);
            dim_h[k] = ((hc >> k) == '0) ? mpbr_pkg::DIM_W'(1) : (hc >> k);
        end
        lvl_en[0] = 1'b1;
        for (int k = 1; k <= L; k++)
        begin
            lvl_en[k] = dim_w[k-1] > mpbr_pkg::DIM_W'(1) || dim_h[k-1] > mpbr_pkg::DIM_W'(1);
        end
        for (int k = 0; k < L; k++)
        begin
            geom[k].en   = lvl_en[k+1];
            geom[k].last = lvl_en[k+1] && ((k == L - 1) || !lvl_en[(k+2 > L) ? L : k+2]);
            geom[k].sx   = dim_w[k];
            geom[k].sy   = dim_h[k];
            geom[k].dx   = dim_w[k+1];
            geom[k].dy   = dim_h[k+1];
        end
    end

    always_comb
    begin
        chain[0]          = '0;
        chain[0].valid    = in_valid;
        chain[0].alive    = 1'b1;
        chain[0].px.blue  = in_blue;
        chain[0].px.green = in_green;
        chain[0].px.red   = in_red;
        chain[0].px.alpha = in_alpha;
    end

    assign in_ready = adv;

    for (genvar k = 0; k < L; k++)
    begin : g_lvl
        localparam int AW    = mpbr_pkg::ram_aw(k + 1);
        localparam int DEPTH = mpbr_pkg::ram_depth(k + 1);

        mpbr_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .adv       (adv),
            .restart   (restart),
            .lvl_idx   (mpbr_pkg::LIDX_W'(k)),
            .geom      (geom[k]),
            .tok_in    (chain[k]),
            .tok_out   (chain[k+1]),
            .ram_req   (req[k]),
            .ram_rdata (rdata[k])
        );

        mpbr_ram #(
            .WIDTH ($bits(mpbr_pkg::hs_t)),
            .DEPTH (DEPTH)
        ) u_upper (
            .clk   (clk),
            .we    (req[k].we),
            .waddr (req[k].addr[AW-1:0]),
            .wdata (req[k].wdata),
            .re    (req[k].re),
            .raddr (req[k].addr[AW-1:0]),
            .rdata (rdata[k])
        );
    end

    mpbr_serializer u_ser (
        .clk             (clk),
        .rst_n           (rst_n),
        .tail            (chain[L]),
        .adv             (adv),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .level           (level),
        .out_x           (out_x),
        .out_y           (out_y),
        .out_blue        (out_blue),
        .out_green       (out_green),
        .out_red         (out_red),
        .out_alpha       (out_alpha),
        .last_of_run     (last_of_run),
        .last_of_pyramid (last_of_pyramid)
    );

endmodule

@@ design/mpbr_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module mpbr_ram #(
    parameter int WIDTH = 36,
    parameter int DEPTH = 16
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ design/mpbr_cell.sv @@
// One pyramid level: source position counters, horizontal pairing, vertical
// pairing against the level's upper-row store, and the rounded 2x2 mean.
// Depends on mpbr_pkg.
module mpbr_cell (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            adv,
    input  logic                            restart,
    input  logic [mpbr_pkg::LIDX_W-1:0]     lvl_idx,
    input  mpbr_pkg::geom_t                 geom,
    input  mpbr_pkg::tok_t                  tok_in,
    output mpbr_pkg::tok_t                  tok_out,
    output mpbr_pkg::ram_req_t              ram_req,
    input  mpbr_pkg::hs_t                   ram_rdata
);

    logic [mpbr_pkg::CNT_W-1:0]   col_reg, col_next;
    logic [mpbr_pkg::CNT_W-1:0]   row_reg, row_next;
    mpbr_pkg::pix_t               pend_reg;
    mpbr_pkg::tok_t               a_tok_reg, a_tok_next;
    mpbr_pkg::hs_t                a_hs_reg, hs;
    logic [mpbr_pkg::COORD_W-1:0] a_x_reg, a_y_reg, x, y;
    logic                         a_use_ram_reg;
    mpbr_pkg::tok_t               out_reg, out_next;

    logic [mpbr_pkg::DIM_W-1:0]   c_inc, r_inc, c_ext, r_ext;
    logic                         act, drop, h_pair, v_pair, h_done;
    logic                         store_left, v_store, emit;

    function automatic logic [mpbr_pkg::CH_W-1:0] mean4(
        input logic [mpbr_pkg::HS_W-1:0] a,
        input logic [mpbr_pkg::HS_W-1:0] b
    );
        logic [mpbr_pkg::SUM_W-1:0] s;
        s = mpbr_pkg::SUM_W'(a) + mpbr_pkg::SUM_W'(b) + mpbr_pkg::SUM_W'(2);
        return s[mpbr_pkg::SUM_W-1:2];
    endfunction

    // stage A: position bookkeeping and pairing decisions
    always_comb
    begin
        act    = tok_in.valid && tok_in.alive && geom.en;
        c_ext  = mpbr_pkg::DIM_W'(col_reg);
        r_ext  = mpbr_pkg::DIM_W'(row_reg);
        c_inc  = c_ext + mpbr_pkg::DIM_W'(1);
        r_inc  = r_ext + mpbr_pkg::DIM_W'(1);
        h_pair = geom.sx > mpbr_pkg::DIM_W'(1);
        v_pair = geom.sy > mpbr_pkg::DIM_W'(1);

        col_next = col_reg;
        row_next = row_reg;
        if (act)
        begin
            if (c_inc >= geom.sx)
            begin
                col_next = '0;
                row_next = (r_inc >= geom.sy) ? '0 : r_inc[mpbr_pkg::CNT_W-1:0];
            end
            else
            begin
                col_next = c_inc[mpbr_pkg::CNT_W-1:0];
            end
        end

        // trailing odd column or row
        drop = (h_pair && c_ext >= (geom.dx << 1)) || (v_pair && r_ext >= (geom.dy << 1));

        if (h_pair)
        begin
            hs.blue  = mpbr_pkg::HS_W'(pend_reg.blue)  + mpbr_pkg::HS_W'(tok_in.px.blue);
            hs.green = mpbr_pkg::HS_W'(pend_reg.green) + mpbr_pkg::HS_W'(tok_in.px.green);
            hs.red   = mpbr_pkg::HS_W'(pend_reg.red)   + mpbr_pkg::HS_W'(tok_in.px.red);
            hs.alpha = mpbr_pkg::HS_W'(pend_reg.alpha) + mpbr_pkg::HS_W'(tok_in.px.alpha);
            x        = col_reg[mpbr_pkg::CNT_W-1:1];
        end
        else
        begin
            hs.blue  = {tok_in.px.blue,  1'b0};
            hs.green = {tok_in.px.green, 1'b0};
            hs.red   = {tok_in.px.red,   1'b0};
            hs.alpha = {tok_in.px.alpha, 1'b0};
            x        = '0;
        end
        y = v_pair ? row_reg[mpbr_pkg::CNT_W-1:1] : '0;

        h_done     = !h_pair || col_reg[0];
        store_left = act && !drop && !h_done;
        v_store    = act && !drop && h_done && v_pair && !row_reg[0];
        emit       = act && !drop && h_done && (!v_pair || row_reg[0]);

        ram_req.we    = adv && v_store;
        ram_req.re    = adv && emit && v_pair;
        ram_req.addr  = x;
        ram_req.wdata = hs;

        a_tok_next       = tok_in;
        a_tok_next.alive = emit;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg   <= '0;
            row_reg   <= '0;
            a_tok_reg <= '0;
            out_reg   <= '0;
        end
        else if (restart)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (adv)
        begin
            col_reg   <= col_next;
            row_reg   <= row_next;
            a_tok_reg <= a_tok_next;
            out_reg   <= out_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_hs_reg      <= hs;
            a_x_reg       <= x;
            a_y_reg       <= y;
            a_use_ram_reg <= v_pair;
            if (store_left)
            begin
                pend_reg <= tok_in.px;
            end
        end
    end

    // stage B: vertical sum and rounded mean; without an upper row the sum doubles
    always_comb
    begin
        mpbr_pkg::hs_t  up;
        mpbr_pkg::pix_t m;
        up      = a_use_ram_reg ? ram_rdata : a_hs_reg;
        m.blue  = mean4(a_hs_reg.blue,  up.blue);
        m.green = mean4(a_hs_reg.green, up.green);
        m.red   = mean4(a_hs_reg.red,   up.red);
        m.alpha = mean4(a_hs_reg.alpha, up.alpha);

        out_next    = a_tok_reg;
        out_next.px = m;
        if (a_tok_reg.valid && a_tok_reg.alive)
        begin
            out_next.res[lvl_idx].valid = 1'b1;
            out_next.res[lvl_idx].x     = a_x_reg;
            out_next.res[lvl_idx].y     = a_y_reg;
            out_next.res[lvl_idx].px    = m;
            out_next.res[lvl_idx].lop   = geom.last
                && (mpbr_pkg::DIM_W'(a_x_reg) + mpbr_pkg::DIM_W'(1) == geom.dx)
                && (mpbr_pkg::DIM_W'(a_y_reg) + mpbr_pkg::DIM_W'(1) == geom.dy);
        end
    end

    assign tok_out = out_reg;

endmodule

@@ design/mpbr_serializer.sv @@
// Output stage: holds the level results of one base pixel and hands them
// out one per cycle while out_ready is high, lowest level first. Its release
// drives the chain advance. Depends on mpbr_pkg.
module mpbr_serializer (
    input  logic                           clk,
    input  logic                           rst_n,
    input  mpbr_pkg::tok_t                 tail,
    output logic                           adv,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [mpbr_pkg::LVL_W-1:0]     level,
    output logic [mpbr_pkg::COORD_W-1:0]   out_x,
    output logic [mpbr_pkg::COORD_W-1:0]   out_y,
    output logic [mpbr_pkg::CH_W-1:0]      out_blue,
    output logic [mpbr_pkg::CH_W-1:0]      out_green,
    output logic [mpbr_pkg::CH_W-1:0]      out_red,
    output logic [mpbr_pkg::CH_W-1:0]      out_alpha,
    output logic                           last_of_run,
    output logic                           last_of_pyramid
);

    logic [mpbr_pkg::MAX_LEVELS-1:0]       mask_reg, mask_next, new_mask;
    mpbr_pkg::res_t [mpbr_pkg::MAX_LEVELS-1:0] res_reg;
    logic [mpbr_pkg::LIDX_W-1:0]           sel;
    logic                                  one_left, fire;

    always_comb
    begin
        sel = '0;
        for (int i = mpbr_pkg::MAX_LEVELS - 1; i >= 0; i--)
        begin
            if (mask_reg[i])
            begin
                sel = mpbr_pkg::LIDX_W'(i);
            end
        end
        for (int i = 0; i < mpbr_pkg::MAX_LEVELS; i++)
        begin
            new_mask[i] = tail.valid && tail.res[i].valid;
        end

        one_left  = (mask_reg & (mask_reg - 1'b1)) == '0;
        out_valid = |mask_reg;
        fire      = out_valid && out_ready;
        adv       = !out_valid || (fire && one_left);

        mask_next = mask_reg;
        if (fire)
        begin
            mask_next[sel] = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg <= '0;
        end
        else if (adv)
        begin
            mask_reg <= new_mask;
        end
        else
        begin
            mask_reg <= mask_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            res_reg <= tail.res;
        end
    end

    assign level           = mpbr_pkg::LVL_W'(sel) + mpbr_pkg::LVL_W'(1);
    assign out_x           = res_reg[sel].x;
    assign out_y           = res_reg[sel].y;
    assign out_blue        = res_reg[sel].px.blue;
    assign out_green       = res_reg[sel].px.green;
    assign out_red         = res_reg[sel].px.red;
    assign out_alpha       = res_reg[sel].px.alpha;
    assign last_of_run     = one_left;
    assign last_of_pyramid = res_reg[sel].lop;

endmodule

@@ design/mpbr_checker.sv @@
// Port-level checks for the mip pyramid builder, bound to the top level.
// Depends on mpbr_pkg and mip_pyramid_box_reduce.
module mpbr_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             out_valid,
    input logic                             out_ready,
    input logic [mpbr_pkg::LVL_W-1:0]       level,
    input logic [mpbr_pkg::COORD_W-1:0]     out_x,
    input logic [mpbr_pkg::COORD_W-1:0]     out_y,
    input logic                             last_of_run,
    input logic                             last_of_pyramid
);

    // a stalled item holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(level) && $stable(out_x)
            && $stable(out_y) && $stable(last_of_run))
        else $error("output item changed while stalled");

    // the deepest pixel always closes its run
    a_lop_closes: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && last_of_pyramid |-> last_of_run)
        else $error("last_of_pyramid without last_of_run");

    // levels within a run follow one another without gaps
    a_run_levels: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !last_of_run
            |=> out_valid && level == mpbr_pkg::LVL_W'($past(level) + 1'b1))
        else $error("level sequence broken inside a run");

    // a new run starts at level 1
    a_run_start: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && last_of_run |=> !out_valid || level == 4'd1)
        else $error("run did not start at level 1");

    a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> level != '0 && level <= mpbr_pkg::LVL_W'(mpbr_pkg::MAX_LEVELS))
        else $error("level out of range");

endmodule

bind mip_pyramid_box_reduce mpbr_checker u_mpbr_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .level           (level),
    .out_x           (out_x),
    .out_y           (out_y),
    .last_of_run     (last_of_run),
    .last_of_pyramid (last_of_pyramid)
);

@@ test/mip_pyramid_box_reduce_tb.sv @@
// Self-checking testbench for mip_pyramid_box_reduce: streams base pixels under random
// handshake gaps and checks every level pixel against an in-bench pyramid predictor.
// Depends on mpbr_pkg and the design sources.
module mip_pyramid_box_reduce_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [mpbr_pkg::CFG_IDX_W-1:0] REG_SPARE_A = mpbr_pkg::CFG_IDX_W'(2);
    localparam logic [mpbr_pkg::CFG_IDX_W-1:0] REG_SPARE_B = mpbr_pkg::CFG_IDX_W'(3);

    typedef struct packed {
        logic [mpbr_pkg::LVL_W-1:0]        lvl;
        logic [mpbr_pkg::COORD_W-1:0]      x;
        logic [mpbr_pkg::COORD_W-1:0]      y;
        logic [3:0][mpbr_pkg::CH_W-1:0]    ch;   // blue, green, red, alpha
        logic                              lor;
        logic                              lop;
    } level_pix_t;

    class pyramid_scoreboard;
        int unsigned reg_w, reg_h;
        int unsigned dim_w[mpbr_pkg::MAX_LEVELS+1], dim_h[mpbr_pkg::MAX_LEVELS+1];
        int unsigned slot[mpbr_pkg::MAX_LEVELS+1];
        int unsigned nlev;
        int unsigned col[mpbr_pkg::MAX_LEVELS], row[mpbr_pkg::MAX_LEVELS];
        bit [15:0]   upper[mpbr_pkg::MAX_WIDTH][4];
        bit [15:0]   left[mpbr_pkg::MAX_LEVELS][4];
        level_pix_t  due_q[$];
        int          errors;
        int          shown;

        function new();
            reg_w = 256;
            reg_h = 256;
            errors = 0;
            shown = 0;
            rebuild();
        endfunction

        function int unsigned clamp(int unsigned v);
            if (v < 1) return 1;
            if (v > mpbr_pkg::MAX_WIDTH) return mpbr_pkg::MAX_WIDTH;
            return v;
        endfunction

        function void rebuild();
            int unsigned w, h, off;
            w = clamp(reg_w);
            h = clamp(reg_h);
            off = 0;
            nlev = 0;
            dim_w[0] = w;
            dim_h[0] = h;
            slot[0] = 0;
            while ((w > 1 || h > 1) && nlev < mpbr_pkg::MAX_LEVELS)
            begin
                w = (w >> 1) ? (w >> 1) : 1;
                h = (h >> 1) ? (h >> 1) : 1;
                nlev++;
                dim_w[nlev] = w;
                dim_h[nlev] = h;
                slot[nlev] = off;
                off += w;
            end
            for (int i = 0; i < mpbr_pkg::MAX_LEVELS; i++)
            begin
                col[i] = 0;
                row[i] = 0;
            end
        endfunction

        function void write_reg(logic [mpbr_pkg::CFG_IDX_W-1:0] idx,
                                logic [mpbr_pkg::CFG_W-1:0] val);
            if (idx == mpbr_pkg::REG_BASE_WIDTH) reg_w = val;
            else if (idx == mpbr_pkg::REG_BASE_HEIGHT) reg_h = val;
            else return;
            rebuild();
        endfunction

        // predicts every level pixel completed by one accepted base pixel
        function void note_pixel(logic [3:0][mpbr_pkg::CH_W-1:0] pin);
            int unsigned px[4], hs[4], sm[4];
            int unsigned s, sx, sy, dx, dy, c, r, x, y, idx;
            int          first;
            level_pix_t  e;
            first = due_q.size();
            for (int ch = 0; ch < 4; ch++) px[ch] = pin[ch];
            for (int k = 1; k <= nlev; k++)
            begin
                s = k - 1;
                sx = dim_w[s]; sy = dim_h[s];
                dx = dim_w[k]; dy = dim_h[k];
                c = col[s]; r = row[s];
                if (c + 1 >= sx)
                begin
                    col[s] = 0;
                    row[s] = (r + 1 >= sy) ? 0 : r + 1;
                end
                else
                    col[s] = c + 1;
                if ((sx >= 2 && c >= 2 * dx) || (sy >= 2 && r >= 2 * dy)) break;
                if (sx >= 2)
                begin
                    if (c[0] == 1'b0)
                    begin
                        for (int ch = 0; ch < 4; ch++) left[s][ch] = 16'(px[ch]);
                        break;
                    end
                    for (int ch = 0; ch < 4; ch++) hs[ch] = left[s][ch] + px[ch];
                    x = c >> 1;
                end
                else
                begin
                    for (int ch = 0; ch < 4; ch++) hs[ch] = 2 * px[ch];
                    x = 0;
                end
                if (sy >= 2)
                begin
                    idx = slot[k] + x;
                    if (r[0] == 1'b0)
                    begin
                        if (idx < mpbr_pkg::MAX_WIDTH)
                            for (int ch = 0; ch < 4; ch++) upper[idx][ch] = 16'(hs[ch]);
                        break;
                    end
                    for (int ch = 0; ch < 4; ch++)
                        sm[ch] = ((idx < mpbr_pkg::MAX_WIDTH) ? upper[idx][ch] : 0) + hs[ch];
                    y = r >> 1;
                end
                else
                begin
                    for (int ch = 0; ch < 4; ch++) sm[ch] = 2 * hs[ch];
                    y = 0;
                end
                for (int ch = 0; ch < 4; ch++) px[ch] = ((sm[ch] + 2) >> 2) & 8'hff;
                e.lvl = mpbr_pkg::LVL_W'(k);
                e.x = mpbr_pkg::COORD_W'(x);
                e.y = mpbr_pkg::COORD_W'(y);
                for (int ch = 0; ch < 4; ch++) e.ch[ch] = mpbr_pkg::CH_W'(px[ch]);
                e.lor = 1'b0;
                e.lop = (k == nlev && x + 1 == dx && y + 1 == dy);
                due_q.push_back(e);
            end
            if (due_q.size() > first) due_q[due_q.size()-1].lor = 1'b1;
        endfunction

        function void check(level_pix_t got);
            level_pix_t want;
            if (due_q.size() == 0)
            begin
                errors++;
                if (shown < 10)
                begin
                    shown++;
                    $display("unexpected level pixel: %p", got);
                end
                return;
            end
            want = due_q.pop_front();
            if (got !== want)
            begin
                errors++;
                if (shown < 10)
                begin
                    shown++;
                    $display("mismatch: expected %p", want);
                    $display("          actual   %p", got);
                end
            end
        endfunction

        function int pending();
            return due_q.size();
        endfunction
    endclass

    logic                              clk;
    logic                              rst_n;
    logic                              cfg_we;
    logic [mpbr_pkg::CFG_IDX_W-1:0]    cfg_index;
    logic [mpbr_pkg::CFG_W-1:0]        cfg_data;
    logic                              in_valid;
    logic                              in_ready;
    logic [mpbr_pkg::CH_W-1:0]         in_blue, in_green, in_red, in_alpha;
    logic                              out_valid;
    logic                              out_ready;
    logic [mpbr_pkg::LVL_W-1:0]        level;
    logic [mpbr_pkg::COORD_W-1:0]      out_x, out_y;
    logic [mpbr_pkg::CH_W-1:0]         out_blue, out_green, out_red, out_alpha;
    logic                              last_of_run, last_of_pyramid;

    pyramid_scoreboard sb;
    int unsigned       pixels_taken;
    bit                steady;      // no idling on either side while set
    int                items_sent;

    mip_pyramid_box_reduce dut (.*);

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #50ms;
        $display("mip_pyramid_box_reduce_tb: errors");
        $finish;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_we) sb.write_reg(cfg_index, cfg_data);
            if (in_valid && in_ready)
            begin
                sb.note_pixel({in_alpha, in_red, in_green, in_blue});
                pixels_taken++;
            end
            if (out_valid && out_ready)
                sb.check({level, out_x, out_y, out_alpha, out_red, out_green, out_blue,
                          last_of_run, last_of_pyramid});
        end
    end

    function automatic int gap_len();
        int p;
        if (steady) return 0;
        p = $urandom_range(0, 99);
        if (p < 55) return 0;
        if (p < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // receiver: holds ready low for random stretches
    initial
    begin
        int hold;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            out_ready = 1'b1;
            hold = gap_len();
            if (hold > 0)
            begin
                @(negedge clk);
                out_ready = 1'b0;
                repeat (hold - 1) @(negedge clk);
            end
        end
    end

    task automatic send_pixel(logic [mpbr_pkg::CH_W-1:0] b, logic [mpbr_pkg::CH_W-1:0] g,
                              logic [mpbr_pkg::CH_W-1:0] r, logic [mpbr_pkg::CH_W-1:0] a);
        int unsigned seen;
        int          idle;
        idle = gap_len();
        if (idle > 0)
        begin
            in_valid <= 1'b0;
            repeat (idle) @(negedge clk);
        end
        seen = pixels_taken;
        in_valid <= 1'b1;
        in_blue <= b;
        in_green <= g;
        in_red <= r;
        in_alpha <= a;
        do @(negedge clk); while (pixels_taken == seen);
        items_sent++;
    endtask

    function automatic logic [mpbr_pkg::CH_W-1:0] chan_val();
        int p;
        p = $urandom_range(0, 9);
        if (p == 0) return '0;
        if (p == 1) return '1;
        return mpbr_pkg::CH_W'($urandom_range(0, 255));
    endfunction

    task automatic send_random(int n);
        for (int i = 0; i < n; i++) send_pixel(chan_val(), chan_val(), chan_val(), chan_val());
        in_valid <= 1'b0;
    endtask

    // input is already idle here: drain outstanding level pixels, let the chain
    // empty, then write a register
    task automatic write_reg(logic [mpbr_pkg::CFG_IDX_W-1:0] idx,
                             logic [mpbr_pkg::CFG_W-1:0] val);
        @(negedge clk);
        while (sb.pending() != 0) @(negedge clk);
        repeat (4 * mpbr_pkg::MAX_LEVELS + 20) @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_dims(int unsigned w, int unsigned h);
        write_reg(mpbr_pkg::REG_BASE_WIDTH, mpbr_pkg::CFG_W'(w));
        write_reg(mpbr_pkg::REG_BASE_HEIGHT, mpbr_pkg::CFG_W'(h));
    endtask

    initial
    begin
        int unsigned w, h, n, area;
        sb = new();
        pixels_taken = 0;
        items_sent = 0;
        steady = 1'b0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_valid = 1'b0;
        in_blue = '0;
        in_green = '0;
        in_red = '0;
        in_alpha = '0;
        repeat (4) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // writes beyond the register list are dropped
        write_reg(REG_SPARE_A, 13'd3);
        write_reg(REG_SPARE_B, 13'd5);
        // zero dimensions act as 1x1: nothing comes out
        set_dims(0, 0);
        send_pixel(8'h00, 8'hff, 8'h00, 8'hff);
        send_pixel(8'hff, 8'h00, 8'hff, 8'h00);
        in_valid <= 1'b0;
        // rounding extremes on a 2x2, twice to cross a frame boundary
        set_dims(2, 2);
        send_pixel(8'hff, 8'h00, 8'h01, 8'hff);
        send_pixel(8'hff, 8'h00, 8'h00, 8'hff);
        send_pixel(8'hff, 8'h00, 8'h00, 8'hfe);
        send_pixel(8'hff, 8'h00, 8'h01, 8'hff);
        send_random(4);
        // odd width, single row: column repeat in y, trailing column dropped
        set_dims(3, 1);
        send_random(6);
        // single column
        set_dims(1, 5);
        send_random(5);

        // oversized width saturates; start of wide and tall frames
        steady = 1'b1;
        set_dims(8191, 1);
        send_random(48);
        steady = 1'b0;
        set_dims(1, 4096);
        send_random(32);
        set_dims(4096, 4096);
        send_random(24);

        while (items_sent < 280)
        begin
            w = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 20) : $urandom_range(1, 9);
            h = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 20) : $urandom_range(1, 9);
            steady = ($urandom_range(0, 3) == 0);
            set_dims(w, h);
            area = ((w < 1) ? 1 : w) * ((h < 1) ? 1 : h);
            // usually whole frames, sometimes a broken one cut short
            n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, area) : area * $urandom_range(1, 2);
            if (n > 280 - items_sent) n = 280 - items_sent;
            send_random(n);
        end
        steady = 1'b0;

        @(negedge clk);
        while (sb.pending() != 0) @(negedge clk);
        repeat (4 * mpbr_pkg::MAX_LEVELS + 20) @(negedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("mip_pyramid_box_reduce_tb: clean");
        else
            $display("mip_pyramid_box_reduce_tb: errors");
        $finish;
    end
endmodule
